/* rtl/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// Depends on signals named clk and rst_n in the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/ffsa_pkg.sv */
// Shared types and codes of the first-fit segment allocator.
// No dependencies.
package ffsa_pkg;

  // Fixed field widths.
  localparam int unsigned BASE_W   = 16;
  localparam int unsigned REQ_W    = 17;
  localparam int unsigned STATUS_W = 2;

  // Command codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_A,
    ST_SCAN_F,
    ST_DECIDE,
    ST_SHIFT_DN,
    ST_SHIFT_UP,
    ST_INSERT
  } st_t;

endpackage

/* rtl/first_fit_segment_allocator_core.sv */
// First-fit segment allocator: sorted free table in one synchronous memory.
// Depends on ffsa_pkg and assert_macros.svh.
//
// Channel   Direction  Ports                                       Handshake
// request   in         in_command, in_seg_size, in_seg_base        start && !busy
// result    out        out_alloc_base, out_status, out_free_total  out_valid strobe
//
// An item walks the free table one entry a cycle through the memory read port,
// then shifts entries one a cycle when an entry is removed or inserted.
// Allocate scans to the first entry that fits and, when it uses that entry up,
// closes the gap behind it by shifting the later entries down.
// Free scans until it passes its base or the table ends, then decides and,
// when it inserts, shifts the later entries up and then writes the new one.
// The result strobes in the cycle after the item finishes; the receiver
// cannot stall. Reset is synchronous; no clearing pass.
`include "assert_macros.svh"

module first_fit_segment_allocator_core #(
  parameter int unsigned POOL_WORDS    = 65536,
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_command,
  input  logic [ffsa_pkg::REQ_W-1:0]     in_seg_size,
  input  logic [ffsa_pkg::BASE_W-1:0]    in_seg_base,
  output logic                           out_valid,
  output logic [ffsa_pkg::BASE_W-1:0]    out_alloc_base,
  output logic [ffsa_pkg::STATUS_W-1:0]  out_status,
  output logic [ffsa_pkg::REQ_W-1:0]     out_free_total
);

  localparam int unsigned BW  = ffsa_pkg::BASE_W;
  localparam int unsigned PW  = $clog2(POOL_WORDS + 1);
  localparam int unsigned SW  = (PW > ffsa_pkg::REQ_W) ? PW : ffsa_pkg::REQ_W;
  localparam int unsigned AW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EW  = BW + SW;

  localparam logic [SW-1:0] POOL_S = SW'(POOL_WORDS);
  localparam logic [CW-1:0] TE_C   = CW'(TABLE_ENTRIES);

  // Adds two sizes and clamps at the pool size.
  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, POOL_S}) ? POOL_S : s[SW-1:0];
  endfunction

  // Free table memory and its read port.
  logic [EW-1:0] mem [TABLE_ENTRIES];
  logic [EW-1:0] rdata_r;
  logic          rd_init_r;
  logic          init_r;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;

  ffsa_pkg::st_t state_r, state_nxt;

  logic                    cmd_r, cmd_nxt;
  logic [SW-1:0]           req_r, req_nxt;
  logic [BW-1:0]           base_r, base_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [SW-1:0]           free_r, free_nxt;
  logic [BW-1:0]           grant_r, grant_nxt;
  logic [BW-1:0]           prev_base_r, prev_base_nxt;
  logic [SW-1:0]           prev_size_r, prev_size_nxt;
  logic                    has_prev_r, has_prev_nxt;
  logic [BW-1:0]           succ_base_r, succ_base_nxt;
  logic [SW-1:0]           succ_size_r, succ_size_nxt;
  logic                    has_succ_r, has_succ_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [BW-1:0]           out_base_r, out_base_nxt;
  logic [ffsa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ffsa_pkg::REQ_W-1:0]    out_total_r, out_total_nxt;

  logic [EW-1:0] eff;
  logic [BW-1:0] e_base;
  logic [SW-1:0] e_size;
  logic [CW-1:0] idx1, idx2, idxm1, posm1, posp1;
  logic          jp, jn;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r   <= mem[rd_addr];
    rd_init_r <= init_r && (rd_addr == '0);
  end

  // Entry zero reads as the whole pool until it is first written.
  assign eff    = rd_init_r ? {{BW{1'b0}}, POOL_S} : rdata_r;
  assign e_base = eff[EW-1:SW];
  assign e_size = eff[SW-1:0];

  assign idx1  = idx_r + CW'(1);
  assign idx2  = idx_r + CW'(2);
  assign idxm1 = idx_r - CW'(1);
  assign posm1 = pos_r - CW'(1);
  assign posp1 = pos_r + CW'(1);

  // Touching tests on widened sums, without wrap.
  assign jp = has_prev_r && (({1'b0, SW'(prev_base_r)} + {1'b0, prev_size_r}) ==
                             {1'b0, SW'(base_r)});
  assign jn = has_succ_r && (({1'b0, SW'(base_r)} + {1'b0, req_r}) ==
                             {1'b0, SW'(succ_base_r)});

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffsa_pkg::ST_IDLE;
      count_r     <= CW'(1);
      free_r      <= POOL_S;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      if (we && (wa == '0)) begin
        init_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    req_r        <= req_nxt;
    base_r       <= base_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    grant_r      <= grant_nxt;
    prev_base_r  <= prev_base_nxt;
    prev_size_r  <= prev_size_nxt;
    has_prev_r   <= has_prev_nxt;
    succ_base_r  <= succ_base_nxt;
    succ_size_r  <= succ_size_nxt;
    has_succ_r   <= has_succ_nxt;
    out_base_r   <= out_base_nxt;
    out_status_r <= out_status_nxt;
    out_total_r  <= out_total_nxt;
  end

  // Sequencer: next state, memory accesses and result.
  always_comb begin
    logic fin;
    logic [ffsa_pkg::STATUS_W-1:0] st;
    fin            = 1'b0;
    st             = ffsa_pkg::STAT_OK;
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    req_nxt        = req_r;
    base_nxt       = base_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    free_nxt       = free_r;
    grant_nxt      = grant_r;
    prev_base_nxt  = prev_base_r;
    prev_size_nxt  = prev_size_r;
    has_prev_nxt   = has_prev_r;
    succ_base_nxt  = succ_base_r;
    succ_size_nxt  = succ_size_r;
    has_succ_nxt   = has_succ_r;
    out_valid_nxt  = 1'b0;
    out_base_nxt   = out_base_r;
    out_status_nxt = out_status_r;
    out_total_nxt  = out_total_r;
    rd_addr        = idx1[AW-1:0];
    we             = 1'b0;
    wa             = idx_r[AW-1:0];
    wd             = eff;

    unique case (state_r)
      ffsa_pkg::ST_IDLE: begin
        rd_addr = '0;
        if (start) begin
          cmd_nxt      = in_command;
          req_nxt      = SW'(in_seg_size);
          base_nxt     = in_seg_base;
          idx_nxt      = '0;
          grant_nxt    = '0;
          has_prev_nxt = 1'b0;
          has_succ_nxt = 1'b0;
          pos_nxt      = '0;
          if (in_command == ffsa_pkg::CMD_ALLOC) begin
            if (count_r == '0) begin
              fin = 1'b1;
              st  = ffsa_pkg::STAT_NOFIT;
            end else begin
              state_nxt = ffsa_pkg::ST_SCAN_A;
            end
          end else if (in_seg_size == '0) begin
            fin = 1'b1;
          end else if (count_r == '0) begin
            state_nxt = ffsa_pkg::ST_DECIDE;
          end else begin
            state_nxt = ffsa_pkg::ST_SCAN_F;
          end
        end
      end

      ffsa_pkg::ST_SCAN_A: begin
        if (e_size >= req_r) begin
          grant_nxt = e_base;
          free_nxt  = (free_r >= req_r) ? free_r - req_r : '0;
          if (e_size == req_r) begin
            if (idx1 < count_r) begin
              state_nxt = ffsa_pkg::ST_SHIFT_DN;
            end else begin
              count_nxt = count_r - CW'(1);
              fin       = 1'b1;
            end
          end else begin
            we  = 1'b1;
            wd  = {e_base + req_r[BW-1:0], e_size - req_r};
            fin = 1'b1;
          end
        end else if (idx1 >= count_r) begin
          fin = 1'b1;
          st  = ffsa_pkg::STAT_NOFIT;
        end else begin
          idx_nxt = idx1;
        end
      end

      ffsa_pkg::ST_SCAN_F: begin
        if (e_base <= base_r) begin
          prev_base_nxt = e_base;
          prev_size_nxt = e_size;
          has_prev_nxt  = 1'b1;
          if (idx1 >= count_r) begin
            pos_nxt   = count_r;
            state_nxt = ffsa_pkg::ST_DECIDE;
          end else begin
            idx_nxt = idx1;
          end
        end else begin
          pos_nxt       = idx_r;
          succ_base_nxt = e_base;
          succ_size_nxt = e_size;
          has_succ_nxt  = 1'b1;
          state_nxt     = ffsa_pkg::ST_DECIDE;
        end
      end

      ffsa_pkg::ST_DECIDE: begin
        if (!jp && !jn && (count_r >= TE_C)) begin
          fin = 1'b1;
          st  = ffsa_pkg::STAT_FULL;
        end else begin
          free_nxt = sat_add(free_r, req_r);
          if (jp && jn) begin
            we = 1'b1;
            wa = posm1[AW-1:0];
            wd = {prev_base_r, sat_add(prev_size_r, sat_add(req_r, succ_size_r))};
            if (posp1 < count_r) begin
              rd_addr   = posp1[AW-1:0];
              idx_nxt   = pos_r;
              state_nxt = ffsa_pkg::ST_SHIFT_DN;
            end else begin
              count_nxt = count_r - CW'(1);
              fin       = 1'b1;
            end
          end else if (jp) begin
            we  = 1'b1;
            wa  = posm1[AW-1:0];
            wd  = {prev_base_r, sat_add(prev_size_r, req_r)};
            fin = 1'b1;
          end else if (jn) begin
            we  = 1'b1;
            wa  = pos_r[AW-1:0];
            wd  = {base_r, sat_add(req_r, succ_size_r)};
            fin = 1'b1;
          end else if (pos_r == count_r) begin
            we        = 1'b1;
            wa        = pos_r[AW-1:0];
            wd        = {base_r, sat_add(req_r, '0)};
            count_nxt = count_r + CW'(1);
            fin       = 1'b1;
          end else begin
            rd_addr   = AW'(count_r - CW'(1));
            idx_nxt   = count_r;
            state_nxt = ffsa_pkg::ST_SHIFT_UP;
          end
        end
      end

      ffsa_pkg::ST_SHIFT_DN: begin
        // Close the gap: entry idx+1 moves down to idx.
        we      = 1'b1;
        wa      = idx_r[AW-1:0];
        wd      = eff;
        rd_addr = idx2[AW-1:0];
        idx_nxt = idx1;
        if (idx2 >= count_r) begin
          count_nxt = count_r - CW'(1);
          fin       = 1'b1;
        end
      end

      ffsa_pkg::ST_SHIFT_UP: begin
        // Open a gap: entry idx-1 moves up to idx.
        we = 1'b1;
        wa = idx_r[AW-1:0];
        wd = eff;
        if (idxm1 == pos_r) begin
          state_nxt = ffsa_pkg::ST_INSERT;
        end else begin
          rd_addr = AW'(idx_r - CW'(2));
          idx_nxt = idxm1;
        end
      end

      ffsa_pkg::ST_INSERT: begin
        we        = 1'b1;
        wa        = pos_r[AW-1:0];
        wd        = {base_r, sat_add(req_r, '0)};
        count_nxt = count_r + CW'(1);
        fin       = 1'b1;
      end

      default: begin
        state_nxt = ffsa_pkg::ST_IDLE;
      end
    endcase

    // Result beat for the finished item.
    if (fin) begin
      state_nxt      = ffsa_pkg::ST_IDLE;
      out_valid_nxt  = 1'b1;
      out_status_nxt = st;
      out_base_nxt   = (st == ffsa_pkg::STAT_OK) ? grant_nxt : '0;
      out_total_nxt  = free_nxt[ffsa_pkg::REQ_W-1:0];
    end
  end

  assign busy           = (state_r != ffsa_pkg::ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_alloc_base = out_base_r;
  assign out_status     = out_status_r;
  assign out_free_total = out_total_r;

  // The table never holds more entries than it has room for.
  `ASSERT_IMPL(a_count_bound, 1'b1, count_r <= TE_C)
  // An accepted beat that needs work makes the block busy or gives a result.
  `ASSERT_NEXT(a_accept_moves, start && !busy, busy || out_valid)
  // A failed item never grants a base.
  `ASSERT_IMPL(a_fail_zero, out_valid && (out_status != ffsa_pkg::STAT_OK),
               out_alloc_base == '0)
  // Entry zero stops reading as the pool once it has been written.
  `ASSERT_NEXT(a_init_clear, we && (wa == '0), !init_r)

endmodule
